>>> rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

>>> rtl/lsrb_pkg.sv
// shared constants, types and helper functions of the scan ring buffer
`default_nettype none
package lsrb_pkg;

   localparam int SCAN_SLOTS  = 10;
   localparam int MAX_SAMPLES = 2048;

   localparam int OP_W     = 3;
   localparam int SAMPLE_W = 16;
   localparam int SIDX_W   = 11;
   localparam int ANGLE_W  = 16;
   localparam int STATUS_W = 2;
   localparam int HELD_W   = 4;
   localparam int RES_W    = 7;

   localparam int HALF_TURN = 18000;
   localparam int RES_MIN   = 10;
   localparam int RES_MAX   = 100;
   localparam int RES_RESET = 100;

   localparam int SLOT_W      = $clog2(SCAN_SLOTS);
   localparam int CNT_W       = $clog2(SCAN_SLOTS + 1);
   localparam int SUM_W       = CNT_W + 1;
   localparam int POS_W       = $clog2(MAX_SAMPLES);
   localparam int LEN_W       = $clog2(MAX_SAMPLES + 1);
   localparam int STORE_DEPTH = SCAN_SLOTS * MAX_SAMPLES;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // divider operands: numerator up to 2*half turn + max step, divisor 2*step
   localparam int DIVD_W = $clog2(2 * HALF_TURN + RES_MAX + 1);
   localparam int DIVS_W = RES_W + 1;
   localparam int DIVC_W = $clog2(DIVD_W);

   localparam int SPL_RAW   = (2 * HALF_TURN + RES_RESET) / (2 * RES_RESET) + 1;
   localparam int SPL_RESET = (SPL_RAW > MAX_SAMPLES) ? MAX_SAMPLES : SPL_RAW;

   localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
   localparam logic [OP_W-1:0] OP_READ_OLD = 3'd1;
   localparam logic [OP_W-1:0] OP_POP      = 3'd2;
   localparam logic [OP_W-1:0] OP_READ_ANG = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_ANGLE = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_INDEX = 2'd3;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DIVD_W-1:0] quotient;
   } div_rsp_type;

   // clamp the programmed step to the supported range
   function automatic logic [RES_W-1:0] eff_res(input logic [RES_W-1:0] r);
      logic [RES_W-1:0] c;
      c = r;
      if (r < RES_W'(RES_MIN)) c = RES_W'(RES_MIN);
      if (r > RES_W'(RES_MAX)) c = RES_W'(RES_MAX);
      return c;
   endfunction

   // slot index modulo the ring size, input below twice the ring size
   function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] t;
      t = s;
      if (s >= SUM_W'(SCAN_SLOTS)) t = s - SUM_W'(SCAN_SLOTS);
      return t[SLOT_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] n;
      n = s + 1'b1;
      if (s == SLOT_W'(SCAN_SLOTS - 1)) n = '0;
      return n;
   endfunction

endpackage
`default_nettype wire

>>> rtl/lsrb_channels.sv
// valid/ready channel interfaces of the scan ring buffer
`default_nettype none

interface lsrb_req_if;
   import lsrb_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     opcode;
   logic [SAMPLE_W-1:0] sample;
   logic                end_of_scan;
   logic [SIDX_W-1:0]   sample_index;
   logic [ANGLE_W-1:0]  angle_hundredths;

   modport source (output valid, opcode, sample, end_of_scan, sample_index,
                   angle_hundredths, input ready);
   modport sink (input valid, opcode, sample, end_of_scan, sample_index,
                 angle_hundredths, output ready);
endinterface

interface lsrb_rsp_if;
   import lsrb_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] value;
   logic [STATUS_W-1:0] status;
   logic [HELD_W-1:0]   scans_held;

   modport source (output valid, value, status, scans_held, input ready);
   modport sink (input valid, value, status, scans_held, output ready);
endinterface

interface lsrb_csr_if;
   import lsrb_pkg::*;
   logic             valid;
   logic             ready;
   logic [RES_W-1:0] resolution_hundredths;

   modport source (output valid, resolution_hundredths, input ready);
   modport sink (input valid, resolution_hundredths, output ready);
endinterface

`default_nettype wire

>>> rtl/lsrb_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module lsrb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/lsrb_divider.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module lsrb_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  lsrb_pkg::div_req_type div_req,
   output lsrb_pkg::div_rsp_type div_rsp
);
   import lsrb_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVC_W-1:0] cnt_ff, cnt_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] den_ff, den_in;
   logic [DIVS_W:0]   shifted;
   logic [DIVS_W:0]   diff;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[DIVD_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIVC_W'(DIVD_W - 1);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

>>> rtl/lidar_scan_ring_buffer.sv
// push, pop, clear, padded reads and early errors finish in the execute state; read oldest adds a
// registered store read; read at angle first waits on the shared divider, then reads the store
// unless the result is a padded position or an index error
// one item in flight; the next transfer is taken once the result sits in the output register
// a resolution write stalls the request and config channels while the divider recomputes the length
// reset: ring empty, resolution 100, 181 samples per scan; store not cleared, unread until written
`default_nettype none
`include "assert_macros.svh"
module lidar_scan_ring_buffer (
   input logic         clock,
   input logic         reset,
   lsrb_req_if.sink    req_chan,
   lsrb_rsp_if.source  rsp_chan,
   lsrb_csr_if.sink    csr_chan
);
   import lsrb_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_CFG  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_READ = 3'd4;
   localparam logic [2:0] ST_HOLD = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [RES_W-1:0]  res_ff, res_in;
   logic [LEN_W-1:0]  spl_ff, spl_in;
   logic [SLOT_W-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic [LEN_W-1:0]  len_ff [SCAN_SLOTS];
   logic              len_wr;

   // latched item
   logic [OP_W-1:0]     op_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic                last_ff;
   logic [SIDX_W-1:0]   sidx_ff;
   logic [ANGLE_W-1:0]  angle_ff;

   // result waiting for the output register
   logic [SAMPLE_W-1:0] pend_value_ff;
   logic [STATUS_W-1:0] pend_status_ff;
   logic                pend_load;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_value_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [HELD_W-1:0]   rsp_held_ff;
   logic                load_rsp;
   logic [SAMPLE_W-1:0] load_value;
   logic [STATUS_W-1:0] load_status;

   logic req_xfer;
   logic csr_xfer;
   logic out_free;

   // result of the current step
   logic                fin;
   logic [SAMPLE_W-1:0] fin_value;
   logic [STATUS_W-1:0] fin_status;

   // shared divider
   lsrb_pkg::div_req_type div_req;
   lsrb_pkg::div_rsp_type div_rsp;

   // sample store port
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_addr;
   logic [SAMPLE_W-1:0] ram_rd_data;
   logic [SLOT_W-1:0]   addr_slot;
   logic [POS_W-1:0]    addr_pos;

   // derived ring values
   logic [RES_W-1:0]    eff_r;
   logic [RES_W-1:0]    cfg_r;
   logic [DIVD_W-1:0]   cfg_num;
   logic [ANGLE_W:0]    ang_sum;
   logic [SLOT_W-1:0]   newest_slot;
   logic [SLOT_W-1:0]   len_slot;
   logic [LEN_W-1:0]    len_rd;
   logic [DIVD_W:0]     q_plus;
   logic [LEN_W-1:0]    spl_calc;
   logic [DIVD_W-1:0]   quot;

   // push bookkeeping: a full ring drops its oldest scan at a new scan's first sample
   logic              drop;
   logic [SLOT_W-1:0] push_oldest;
   logic [CNT_W-1:0]  push_count;
   logic [SLOT_W-1:0] push_slot;
   logic              push_room;
   logic [LEN_W-1:0]  push_fill;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign csr_xfer = csr_chan.valid && csr_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // config wins a tie with a request
   assign csr_chan.ready = (state_ff == ST_IDLE);
   assign req_chan.ready = (state_ff == ST_IDLE) && !csr_chan.valid;

   assign eff_r   = eff_res(res_ff);
   assign cfg_r   = eff_res(csr_chan.resolution_hundredths);
   assign cfg_num = DIVD_W'(2 * HALF_TURN) + DIVD_W'(cfg_r);
   // rounded angle / step as (2*angle + step) / (2*step)
   assign ang_sum = {angle_ff, 1'b0} + (ANGLE_W + 1)'(eff_r);
   assign quot    = div_rsp.quotient;

   // scan length = rounded half turn / step + 1, capped at the slot size
   assign q_plus   = (DIVD_W + 1)'(quot) + 1'b1;
   assign spl_calc = (q_plus > (DIVD_W + 1)'(MAX_SAMPLES)) ? LEN_W'(MAX_SAMPLES)
                                                          : q_plus[LEN_W-1:0];

   assign newest_slot = slot_wrap(SUM_W'(oldest_ff) + SUM_W'(count_ff) - SUM_W'(1));
   // one read of the length table: newest slot for angle reads, oldest otherwise
   assign len_slot    = (state_ff == ST_DIV) ? newest_slot : oldest_ff;
   assign len_rd      = len_ff[len_slot];

   assign drop        = (fill_ff == '0) && (count_ff == CNT_W'(SCAN_SLOTS));
   assign push_oldest = drop ? slot_next(oldest_ff) : oldest_ff;
   assign push_count  = drop ? (count_ff - 1'b1) : count_ff;
   assign push_slot   = slot_wrap(SUM_W'(push_oldest) + SUM_W'(push_count));
   assign push_room   = fill_ff < spl_ff;
   assign push_fill   = push_room ? (fill_ff + 1'b1) : fill_ff;

   assign ram_addr = ADDR_W'(addr_slot) * ADDR_W'(MAX_SAMPLES) + ADDR_W'(addr_pos);

   lsrb_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   lsrb_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_addr),
      .wr_data (sample_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      res_in    = res_ff;
      spl_in    = spl_ff;
      oldest_in = oldest_ff;
      count_in  = count_ff;
      fill_in   = fill_ff;
      len_wr    = 1'b0;

      div_req.start    = 1'b0;
      div_req.dividend = ang_sum[DIVD_W-1:0];
      div_req.divisor  = {eff_r, 1'b0};

      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      addr_slot = push_slot;
      addr_pos  = fill_ff[POS_W-1:0];

      fin        = 1'b0;
      fin_value  = '0;
      fin_status = STAT_OK;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_xfer) begin
               // new step: empty the ring and recompute the scan length
               res_in           = csr_chan.resolution_hundredths;
               oldest_in        = '0;
               count_in         = '0;
               fill_in          = '0;
               div_req.start    = 1'b1;
               div_req.dividend = cfg_num;
               div_req.divisor  = {cfg_r, 1'b0};
               state_in         = ST_CFG;
            end else if (req_xfer) begin
               state_in = ST_EXEC;
            end
         end

         ST_CFG: begin
            if (div_rsp.done) begin
               spl_in   = spl_calc;
               state_in = ST_IDLE;
            end
         end

         ST_EXEC: begin
            unique case (op_ff)
               OP_PUSH: begin
                  oldest_in = push_oldest;
                  count_in  = push_count;
                  fill_in   = push_fill;
                  // samples past the scan length are dropped
                  ram_wr_en = push_room;
                  if (last_ff) begin
                     len_wr   = 1'b1;
                     count_in = push_count + 1'b1;
                     fill_in  = '0;
                  end
                  fin = 1'b1;
               end
               OP_READ_OLD: begin
                  addr_slot = oldest_ff;
                  addr_pos  = sidx_ff[POS_W-1:0];
                  if (count_ff == '0) begin
                     fin        = 1'b1;
                     fin_status = STAT_EMPTY;
                  end else if (LEN_W'(sidx_ff) >= spl_ff) begin
                     fin        = 1'b1;
                     fin_status = STAT_INDEX;
                  end else if (LEN_W'(sidx_ff) >= len_rd) begin
                     // padded position of a short scan
                     fin = 1'b1;
                  end else begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_READ;
                  end
               end
               OP_POP: begin
                  if (count_ff == '0) begin
                     fin_status = STAT_EMPTY;
                  end else begin
                     oldest_in = slot_next(oldest_ff);
                     count_in  = count_ff - 1'b1;
                  end
                  fin = 1'b1;
               end
               OP_READ_ANG: begin
                  // angle range is checked ahead of the empty test
                  if (angle_ff > ANGLE_W'(HALF_TURN)) begin
                     fin        = 1'b1;
                     fin_status = STAT_ANGLE;
                  end else if (count_ff == '0) begin
                     fin        = 1'b1;
                     fin_status = STAT_EMPTY;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = ST_DIV;
                  end
               end
               OP_CLEAR: begin
                  oldest_in = '0;
                  count_in  = '0;
                  fill_in   = '0;
                  fin       = 1'b1;
               end
               default: begin
                  // unused opcodes answer ok with no effect
                  fin = 1'b1;
               end
            endcase
         end

         ST_DIV: begin
            addr_slot = newest_slot;
            addr_pos  = quot[POS_W-1:0];
            if (div_rsp.done) begin
               if (quot >= DIVD_W'(spl_ff)) begin
                  fin        = 1'b1;
                  fin_status = STAT_INDEX;
               end else if (quot >= DIVD_W'(len_rd)) begin
                  fin = 1'b1;
               end else begin
                  ram_rd_en = 1'b1;
                  state_in  = ST_READ;
               end
            end
         end

         ST_READ: begin
            fin       = 1'b1;
            fin_value = ram_rd_data;
         end

         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // hand the result to the output register, or park it while the sink stalls
      pend_load = 1'b0;
      if (fin) begin
         if (out_free) begin
            state_in = ST_IDLE;
         end else begin
            pend_load = 1'b1;
            state_in  = ST_HOLD;
         end
      end
   end

   assign load_rsp    = (fin && out_free) || ((state_ff == ST_HOLD) && out_free);
   assign load_value  = (state_ff == ST_HOLD) ? pend_value_ff : fin_value;
   assign load_status = (state_ff == ST_HOLD) ? pend_status_ff : fin_status;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         res_ff       <= RES_W'(RES_RESET);
         spl_ff       <= LEN_W'(SPL_RESET);
         oldest_ff    <= '0;
         count_ff     <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         res_ff       <= res_in;
         spl_ff       <= spl_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // real sample count of each slot
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SCAN_SLOTS; i++) begin
            len_ff[i] <= '0;
         end
      end else if (len_wr) begin
         len_ff[push_slot] <= push_fill;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff     <= req_chan.opcode;
         sample_ff <= req_chan.sample;
         last_ff   <= req_chan.end_of_scan;
         sidx_ff   <= req_chan.sample_index;
         angle_ff  <= req_chan.angle_hundredths;
      end
      if (pend_load) begin
         pend_value_ff  <= fin_value;
         pend_status_ff <= fin_status;
      end
      if (load_rsp) begin
         rsp_value_ff  <= load_value;
         rsp_status_ff <= load_status;
         rsp_held_ff   <= HELD_W'(count_in);
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.value      = rsp_value_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.scans_held = rsp_held_ff;

   // checks
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(SCAN_SLOTS), "ring overfull")
   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= spl_ff, "open scan too long")
   `ASSERT_NEVER(a_div_overlap, clock, reset, div_req.start && div_rsp.busy, "divider restarted")
   `ASSERT_ALWAYS(a_req_leaves_idle, clock, reset, req_xfer |=> state_ff != ST_IDLE, "stuck idle")

endmodule
`default_nettype wire
